// File: rtl/modexp_pkg.sv
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Field widths, register map and the status bundle of the shared
// modular multiplier.
// ----------------------------------------------------------------------------
package modexp_pkg;

    // Width of the base, exponent, modulus and result fields.
    localparam int FIELD_BITS = 31;

    // APB register map: one register at byte address 0.
    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;
    localparam logic [0:0] REG_MODULUS = 1'b0;

    // Status of the shared modular multiplier.
    typedef struct packed {
        logic busy;
        logic done;
    } mm_status_t;

endpackage

// File: rtl/modexp_mulmod.sv
// ----------------------------------------------------------------------------
// Modular multiplier
// Computes (a * b) mod m with one full multiply followed by a restoring
// remainder that takes one product bit per cycle.
// ----------------------------------------------------------------------------
module modexp_mulmod #(
    parameter int OPERAND_BITS = 31
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [OPERAND_BITS-1:0]        op_a,
    input  logic [OPERAND_BITS-1:0]        op_b,
    input  logic [OPERAND_BITS-1:0]        op_m,
    output modexp_pkg::mm_status_t         status,
    output logic [OPERAND_BITS-1:0]        result
);
    import modexp_pkg::*;

    localparam int PROD_BITS = 2 * OPERAND_BITS;
    localparam int CNT_BITS  = $clog2(PROD_BITS);
    localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(PROD_BITS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_RED
    } state_t;

    state_t                  state_reg;
    logic                    done_reg;
    logic [CNT_BITS-1:0]     cnt_reg;
    logic [OPERAND_BITS-1:0] a_reg;
    logic [OPERAND_BITS-1:0] b_reg;
    logic [OPERAND_BITS-1:0] m_reg;
    logic [PROD_BITS-1:0]    prod_reg;
    logic [OPERAND_BITS-1:0] rem_reg;

    logic [OPERAND_BITS:0]   shifted;
    logic [OPERAND_BITS:0]   diff;
    logic [OPERAND_BITS-1:0] rem_next;

    // The remainder stays below m, so after shifting in one bit it is below
    // 2m and a single compare and subtract restores it.
    always_comb begin
        shifted = {rem_reg, prod_reg[PROD_BITS-1]};
        diff    = shifted - {1'b0, m_reg};
        if (shifted >= {1'b0, m_reg}) begin
            rem_next = diff[OPERAND_BITS-1:0];
        end else begin
            rem_next = shifted[OPERAND_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            done_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (start) begin
                        a_reg     <= op_a;
                        b_reg     <= op_b;
                        m_reg     <= op_m;
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    prod_reg  <= PROD_BITS'(a_reg) * PROD_BITS'(b_reg);
                    rem_reg   <= '0;
                    cnt_reg   <= '0;
                    state_reg <= ST_RED;
                end
                ST_RED: begin
                    rem_reg  <= rem_next;
                    prod_reg <= {prod_reg[PROD_BITS-2:0], 1'b0};
                    cnt_reg  <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_LAST) begin
                        done_reg  <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign status.busy = (state_reg != ST_IDLE);
    assign status.done = done_reg;
    assign result      = rem_reg;

endmodule

// File: rtl/modular_exponentiation.sv
// ----------------------------------------------------------------------------
// Modular exponentiation
// Returns base to the exponent modulo a programmed modulus, using
// right-to-left square and multiply on a shared modular multiplier.
// ----------------------------------------------------------------------------
// Usage: program the modulus over the APB port (register 0 at byte address
// 0) while the block is idle; it resets to 1, and a modulus whose low
// OPERAND_BITS bits are zero acts as 1. Each input item carries s_base and
// s_exponent; exactly one item with m_power_mod comes back for each.
// Only the low OPERAND_BITS bits of the operands are used.
// A zero exponent returns 1 with no product on the multiplier. Otherwise
// every modular product runs through the bit-serial remainder of the
// shared multiplier. An item needs one product to reduce the base, one
// per set exponent bit and one square per bit below the top set bit, so
// up to 2*OPERAND_BITS products.
// Throughput: one item at a time; s_ready is high only while the sequencer
// is idle. A finished result waits in the output register while the next
// item is already accepted; if the receiver stalls, the sequencer holds the
// following result until the output register frees up.
// Reset clears the sequencer, the output valid and sets the modulus to 1.
// ----------------------------------------------------------------------------
module modular_exponentiation #(
    parameter int OPERAND_BITS = 31
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // APB configuration port
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [modexp_pkg::APB_ADDR_BITS-1:0]   paddr,
    input  logic [modexp_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic [modexp_pkg::APB_DATA_BITS-1:0]   prdata,
    output logic                                   pready,
    // Input channel
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [modexp_pkg::FIELD_BITS-1:0]      s_base,
    input  logic [modexp_pkg::FIELD_BITS-1:0]      s_exponent,
    // Result channel
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [modexp_pkg::FIELD_BITS-1:0]      m_power_mod
);
    import modexp_pkg::*;

    localparam int OB = OPERAND_BITS;
    localparam logic [OB-1:0] ONE = OB'(1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BASE,
        ST_STEP,
        ST_MULT,
        ST_SQUARE,
        ST_FINISH
    } state_t;

    state_t                  state_reg;
    logic [FIELD_BITS-1:0]   modulus_reg;
    logic [OB-1:0]           m_reg;
    logic [OB-1:0]           b_reg;
    logic [OB-1:0]           e_reg;
    logic [OB-1:0]           acc_reg;
    logic                    mm_start_reg;
    logic [OB-1:0]           mm_a_reg;
    logic [OB-1:0]           mm_b_reg;
    logic                    m_valid_reg;
    logic [FIELD_BITS-1:0]   m_power_mod_reg;

    mm_status_t              mm_status;
    logic [OB-1:0]           mm_result;
    logic [OB-1:0]           mod_trim;
    logic [OB-1:0]           mod_eff;
    logic                    cfg_write;
    logic                    out_free;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_MODULUS);

    always_comb begin
        if (paddr[2] == REG_MODULUS) begin
            prdata = APB_DATA_BITS'(modulus_reg);
        end else begin
            prdata = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modulus_reg <= FIELD_BITS'(1);
        end else if (cfg_write) begin
            modulus_reg <= pwdata[FIELD_BITS-1:0];
        end
    end

    assign mod_trim = modulus_reg[OB-1:0];
    assign mod_eff  = (mod_trim == '0) ? ONE : mod_trim;

    // ------------------------------------------------------------------
    // Shared modular multiplier
    // ------------------------------------------------------------------
    modexp_mulmod #(
        .OPERAND_BITS (OB)
    ) u_mulmod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mm_start_reg),
        .op_a    (mm_a_reg),
        .op_b    (mm_b_reg),
        .op_m    (m_reg),
        .status  (mm_status),
        .result  (mm_result)
    );

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    assign s_ready  = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            mm_start_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            mm_start_reg <= 1'b0;
            // A finished item refills the output register in the same cycle
            // that the waiting one is taken.
            if ((state_reg == ST_FINISH) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        m_reg   <= mod_eff;
                        b_reg   <= s_base[OB-1:0];
                        e_reg   <= s_exponent[OB-1:0];
                        acc_reg <= ONE;
                        if (s_exponent[OB-1:0] == '0) begin
                            state_reg <= ST_FINISH;
                        end else begin
                            // Reduce the base first as base * 1 mod m.
                            mm_a_reg     <= s_base[OB-1:0];
                            mm_b_reg     <= ONE;
                            mm_start_reg <= 1'b1;
                            state_reg    <= ST_BASE;
                        end
                    end
                end
                ST_BASE: begin
                    if (mm_status.done) begin
                        b_reg     <= mm_result;
                        state_reg <= ST_STEP;
                    end
                end
                ST_STEP: begin
                    // A set low bit is consumed by a multiply, then the
                    // base is squared while higher bits remain.
                    if (e_reg == '0) begin
                        state_reg <= ST_FINISH;
                    end else if (e_reg[0]) begin
                        mm_a_reg     <= acc_reg;
                        mm_b_reg     <= b_reg;
                        mm_start_reg <= 1'b1;
                        state_reg    <= ST_MULT;
                    end else begin
                        mm_a_reg     <= b_reg;
                        mm_b_reg     <= b_reg;
                        mm_start_reg <= 1'b1;
                        state_reg    <= ST_SQUARE;
                    end
                end
                ST_MULT: begin
                    if (mm_status.done) begin
                        acc_reg   <= mm_result;
                        e_reg[0]  <= 1'b0;
                        state_reg <= ST_STEP;
                    end
                end
                ST_SQUARE: begin
                    if (mm_status.done) begin
                        b_reg     <= mm_result;
                        e_reg     <= e_reg >> 1;
                        state_reg <= ST_STEP;
                    end
                end
                ST_FINISH: begin
                    if (out_free) begin
                        m_power_mod_reg <= FIELD_BITS'(acc_reg);
                        state_reg       <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_power_mod = m_power_mod_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_idle_unit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !mm_status.busy)
        else $error("multiplier busy while the sequencer is idle");

    a_done_expected: assert property (@(posedge aclk) disable iff (!aresetn)
        mm_status.done |->
            (state_reg == ST_BASE) || (state_reg == ST_MULT) || (state_reg == ST_SQUARE))
        else $error("multiplier finished with no product pending");

    a_product_reduced: assert property (@(posedge aclk) disable iff (!aresetn)
        mm_status.done |-> (mm_result < m_reg))
        else $error("multiplier result not reduced below the modulus");

    a_acc_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_STEP) |-> (acc_reg < m_reg) || (acc_reg == ONE))
        else $error("running result out of range");

endmodule

// File: tb/modular_exponentiation_tb.sv
// ----------------------------------------------------------------------------
// Modular exponentiation testbench
// Programs the modulus over APB and streams base/exponent items through the
// block. Each accepted item is predicted with a square-and-multiply model,
// and every returned power_mod is checked in order against that prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module modular_exponentiation_tb;

    import modexp_pkg::*;

    typedef logic [FIELD_BITS-1:0] operand_t;

    typedef struct {
        operand_t base;
        operand_t exponent;
    } operand_pair_t;

    localparam operand_t FIELD_MAX = {FIELD_BITS{1'b1}};
    localparam logic [APB_ADDR_BITS-1:0] MODULUS_ADDR = {REG_MODULUS, 2'b00};
    // Byte address of register index one, which does not exist.
    localparam logic [APB_ADDR_BITS-1:0] UNMAPPED_ADDR = {~REG_MODULUS, 2'b00};
    localparam int STALL_LIMIT = 60000;
    localparam int HOLD_OFF_CYCLES = 3000;
    localparam int DRAIN_CYCLES = 100;
    localparam int REPORT_LIMIT = 10;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [APB_ADDR_BITS-1:0] paddr = '0;
    logic [APB_DATA_BITS-1:0] pwdata = '0;
    logic [APB_DATA_BITS-1:0] prdata;
    logic pready;

    logic s_valid = 1'b0;
    logic s_ready;
    operand_t s_base = '0;
    operand_t s_exponent = '0;

    logic m_valid;
    logic m_ready = 1'b0;
    operand_t m_power_mod;

    operand_pair_t pending_items[$];
    operand_t power_mod_expected[$];
    operand_t modulus_setting = operand_t'(1);

    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;
    int error_count = 0;
    int stall_cycles = 0;

    modular_exponentiation dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_base      (s_base),
        .s_exponent  (s_exponent),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_power_mod (m_power_mod)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Right-to-left square and multiply; a zero modulus behaves as one.
    function automatic operand_t power_mod_of(operand_t base, operand_t exponent,
                                              operand_t modulus);
        bit [63:0] acc;
        bit [63:0] base_power;
        bit [63:0] m;
        int i;
        if (exponent == '0) begin
            return operand_t'(1);
        end
        m = (modulus == '0) ? 64'd1 : 64'(modulus);
        acc = 64'd1;
        base_power = 64'(base) % m;
        for (i = 0; i < FIELD_BITS; i++) begin
            if (exponent[i]) begin
                acc = (acc * base_power) % m;
            end
            base_power = (base_power * base_power) % m;
        end
        return acc[FIELD_BITS-1:0];
    endfunction

    task automatic note_mismatch(string what, logic [31:0] expected, logic [31:0] actual);
        error_count++;
        if (error_count <= REPORT_LIMIT) begin
            $display("%0t: %s mismatch: expected 0x%08h, got 0x%08h", $realtime, what,
                     expected, actual);
        end
    endtask

    always @(posedge aclk) begin : drive_items
        operand_pair_t next_item;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                power_mod_expected = {power_mod_expected,
                                      power_mod_of(s_base, s_exponent, modulus_setting)};
            end
            if (!s_valid || s_ready) begin
                if (pending_items.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
                    next_item = pending_items.pop_front();
                    s_valid <= 1'b1;
                    s_base <= next_item.base;
                    s_exponent <= next_item.exponent;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : check_results
        operand_t expected;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (power_mod_expected.size() == 0) begin
                    note_mismatch("unexpected power_mod", '0, 32'(m_power_mod));
                end else begin
                    expected = power_mod_expected.pop_front();
                    if (m_power_mod !== expected) begin
                        note_mismatch("power_mod", 32'(expected), 32'(m_power_mod));
                    end
                end
            end
            // A long hold-off lets the block fill up and back-pressure its input.
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_ready <= 1'b0;
            end else if (hold_served != hold_requests) begin
                hold_served <= hold_requests;
                hold_left <= HOLD_OFF_CYCLES;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    task automatic apb_write(logic [APB_ADDR_BITS-1:0] addr, logic [APB_DATA_BITS-1:0] data);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == MODULUS_ADDR) begin
            modulus_setting = data[FIELD_BITS-1:0];
        end
    endtask

    task automatic check_modulus_readback();
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= MODULUS_ADDR;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata[FIELD_BITS-1:0] !== modulus_setting) begin
            note_mismatch("modulus readback", 32'(modulus_setting), prdata);
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic queue_item(operand_t base, operand_t exponent);
        operand_pair_t item;
        item.base = base;
        item.exponent = exponent;
        pending_items = {pending_items, item};
    endtask

    function automatic operand_t random_base();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 4) return '0;
        if (pick < 8) return operand_t'(1);
        if (pick < 12) return modulus_setting - operand_t'(1);
        if (pick < 15) return FIELD_MAX;
        return operand_t'($urandom());
    endfunction

    // Mostly short exponents keep the run length down; about a quarter span
    // all 31 bits so that every exponent bit is exercised.
    function automatic operand_t random_exponent(bit quick);
        int unsigned pick;
        int unsigned span;
        if (quick) return operand_t'($urandom_range(0, 255));
        pick = $urandom_range(0, 99);
        if (pick < 3) return '0;
        if (pick < 5) return operand_t'(1);
        if (pick < 8) return FIELD_MAX;
        if (pick < 30) return operand_t'($urandom());
        span = $urandom_range(1, 16);
        return operand_t'($urandom() & ((32'd1 << span) - 1));
    endfunction

    task automatic queue_random_items(int count, bit quick);
        int n;
        for (n = 0; n < count; n++) begin
            queue_item(random_base(), random_exponent(quick));
        end
    endtask

    task automatic wait_until_drained();
        do begin
            @(negedge aclk);
        end while (pending_items.size() != 0 || s_valid || power_mod_expected.size() != 0);
        repeat (8) @(negedge aclk);
    endtask

    task automatic set_idling(int mode);
        case (mode % 4)
            0: begin
                sender_idle_pct = 0;
                receiver_stall_pct = 0;
            end
            1: begin
                sender_idle_pct = 67;
                receiver_stall_pct = 0;
            end
            2: begin
                sender_idle_pct = 0;
                receiver_stall_pct = 67;
            end
            default: begin
                sender_idle_pct = 6;
                receiver_stall_pct = 6;
            end
        endcase
    endtask

    initial begin : run_test
        operand_t random_moduli[7];
        int phase;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset modulus of one: everything but a zero exponent reduces to zero.
        check_modulus_readback();
        queue_item(operand_t'(5), '0);
        queue_item(operand_t'(12345), operand_t'(3));
        queue_item('0, '0);
        queue_item(FIELD_MAX, FIELD_MAX);
        wait_until_drained();

        apb_write(MODULUS_ADDR, 32'(FIELD_MAX));
        check_modulus_readback();
        queue_item('0, '0);
        queue_item('0, operand_t'(1));
        queue_item(FIELD_MAX, FIELD_MAX);
        queue_item(FIELD_MAX, operand_t'(1));
        queue_item(operand_t'(1), FIELD_MAX);
        queue_item(operand_t'(2), operand_t'(30));
        queue_item(operand_t'(2), operand_t'(31));
        queue_item(operand_t'(2), operand_t'(32'h4000_0000));
        queue_item(FIELD_MAX - operand_t'(1), operand_t'(2));
        queue_item(operand_t'(32'h5555_5555), operand_t'(32'h2AAA_AAAA));
        queue_item(operand_t'(32'h2AAA_AAAA), operand_t'(32'h5555_5555));
        queue_item(operand_t'(32'h4000_0000), operand_t'(2));
        wait_until_drained();

        apb_write(MODULUS_ADDR, 32'd2);
        queue_item(operand_t'(3), operand_t'(5));
        queue_item(operand_t'(4), operand_t'(7));
        wait_until_drained();

        apb_write(MODULUS_ADDR, 32'd1);
        queue_item(operand_t'(7), '0);
        queue_item(operand_t'(7), operand_t'(9));
        wait_until_drained();

        // Only bit 31 set: the stored modulus is zero and acts as one.
        apb_write(MODULUS_ADDR, 32'h8000_0000);
        check_modulus_readback();
        queue_item(operand_t'(9), '0);
        queue_item(operand_t'(9), operand_t'(4));
        wait_until_drained();

        // A write to a register that does not exist leaves the modulus alone.
        apb_write(UNMAPPED_ADDR, 32'd12345);
        check_modulus_readback();
        queue_item(operand_t'(6), operand_t'(1));
        wait_until_drained();

        random_moduli[0] = FIELD_MAX;
        random_moduli[1] = operand_t'($urandom_range(32'h4000_0000, 32'h7FFF_FFFF));
        random_moduli[2] = operand_t'($urandom_range(2, 255));
        random_moduli[3] = operand_t'(3);
        random_moduli[4] = operand_t'(65537);
        random_moduli[5] = operand_t'($urandom_range(1, 32'h7FFF_FFFF));
        random_moduli[6] = operand_t'(2);
        for (phase = 0; phase < 7; phase++) begin
            apb_write(MODULUS_ADDR, 32'(random_moduli[phase]));
            check_modulus_readback();
            set_idling(phase);
            queue_random_items(36, 1'b0);
            wait_until_drained();
        end

        // Receiver holds off while short items keep arriving.
        apb_write(MODULUS_ADDR, 32'd1000003);
        set_idling(0);
        hold_requests = hold_requests + 1;
        queue_random_items(20, 1'b1);
        wait_until_drained();

        repeat (DRAIN_CYCLES) @(posedge aclk);
        error_count += power_mod_expected.size();
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
